>>> src/pacdb_pkg.sv
`timescale 1ns / 1ps

package pacdb_pkg;

   localparam int NUM_CHANNELS_DEF = 8;
   localparam longint unsigned COUNT_LIMIT_DEF = 64'd65535;

   localparam logic [1:0] REQ_CLOCK = 2'd0;
   localparam logic [1:0] REQ_RESET = 2'd1;
   localparam logic [1:0] REQ_SET   = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic       clock_level;
      logic [2:0] channel;
      logic [7:0] divider_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  gate_outputs;
      logic [15:0] master_count;
      logic [7:0]  applied_divider;
   } rsp_payload_type;

endpackage

>>> src/pacdb_rem_div.sv
`timescale 1ns / 1ps

module pacdb_rem_div #(
   parameter int DVD_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [8:0]       divisor,
   output logic             done,
   output logic [8:0]       remainder
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] shift_ff, shift_in;
   logic [8:0]       rem_ff, rem_in;
   logic [9:0]       trial;
   logic [9:0]       diff;

   assign trial = {rem_ff, shift_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (busy_ff) begin
         // One restoring step per cycle, most significant dividend bit first.
         shift_in = shift_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[8:0];
         end else begin
            rem_in = trial[8:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> src/phase_aligned_clock_divider_bank.sv
`timescale 1ns / 1ps

// A level-changing clock request passes S_INC, S_SCAN (one shared compare-and-add per
// channel) and S_DONE; other requests but a set to a valid channel go straight to S_DONE.
// Such a set waits in S_DIV on the bit-serial remainder unit (counter width, 16 bits by
// default), then passes S_SUB and S_SET. One request is in work at a time; the response
// register lets the next request in while a response waits. Synchronous reset clears the
// counter, gates and response valid, and sets each divider and next-toggle count to one.

module phase_aligned_clock_divider_bank #(
   parameter int              NUM_CHANNELS = pacdb_pkg::NUM_CHANNELS_DEF,
   parameter longint unsigned COUNT_LIMIT  = pacdb_pkg::COUNT_LIMIT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pacdb_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pacdb_pkg::rsp_payload_type rsp_payload
);

   localparam int CNT_W = $clog2(COUNT_LIMIT + 64'd1);
   localparam int TOG_W = $clog2(COUNT_LIMIT + 64'd767);
   localparam int ADD_W = TOG_W + 1;
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int GW    = (NUM_CHANNELS > 8) ? NUM_CHANNELS : 8;
   localparam int MW    = (CNT_W > 16) ? CNT_W : 16;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_INC  = 7'b0000010,
      S_SCAN = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_SUB  = 7'b0010000,
      S_SET  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           cur_ff, cur_in;
   logic [IDX_W-1:0]           chan_ff, chan_in;
   logic                       ch_ok_ff, ch_ok_in;
   logic [CNT_W-1:0]           edge_ff, edge_in;
   logic                       last_ff, last_in;
   logic [7:0]                 div_ff [NUM_CHANNELS];
   logic [7:0]                 div_in [NUM_CHANNELS];
   logic [TOG_W-1:0]           tog_ff [NUM_CHANNELS];
   logic [TOG_W-1:0]           tog_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]    gate_ff, gate_in;
   logic [TOG_W-1:0]           p_ff, p_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pacdb_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic             accept;
   logic             req_ch_ok;
   logic [IDX_W-1:0] req_idx;
   logic [7:0]       req_div;
   logic [7:0]       cur_div;
   logic             div_start;
   logic             div_done;
   logic [8:0]       div_rem;
   logic [9:0]       cur_div2;
   logic [9:0]       cur_div3;
   logic [9:0]       offset;
   logic [ADD_W-1:0] opa, opb, sum;
   logic             cin;
   logic [GW-1:0]    gate_ext;
   logic [MW-1:0]    edge_ext;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_ch_ok = (32'(req_payload.channel) < 32'(NUM_CHANNELS));
   assign req_idx   = IDX_W'(req_payload.channel);
   assign req_div   = (req_payload.divider_value == 8'd0) ? 8'd1 : req_payload.divider_value;
   assign cur_div   = div_ff[cur_ff];
   assign cur_div2  = {1'b0, cur_div, 1'b0};
   assign cur_div3  = cur_div2 + {2'b00, cur_div};
   assign div_start = accept && (req_payload.req_type == pacdb_pkg::REQ_SET) && req_ch_ok;

   pacdb_rem_div #(
      .DVD_W(CNT_W)
   ) u_rem_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (edge_ff),
      .divisor  (cur_div2[8:0]),
      .done     (div_done),
      .remainder(div_rem)
   );

   // The next toggle sits one past one, two or three half periods from the start of the period.
   always_comb begin
      if (!gate_ff[cur_ff]) begin
         offset = cur_div2 + 10'd1;
      end else if ({1'b0, div_rem} <= {2'b00, cur_div}) begin
         offset = {2'b00, cur_div} + 10'd1;
      end else begin
         offset = cur_div3 + 10'd1;
      end
   end

   always_comb begin
      opa = '0;
      opb = '0;
      cin = 1'b0;
      unique case (state_ff)
         S_INC: begin
            opa = ADD_W'(edge_ff);
            cin = 1'b1;
         end
         S_SCAN: begin
            opa = ADD_W'(tog_ff[cur_ff]);
            opb = ADD_W'(cur_div);
         end
         S_SUB: begin
            opa = ADD_W'(edge_ff);
            opb = ~ADD_W'(div_rem);
            cin = 1'b1;
         end
         S_SET: begin
            opa = ADD_W'(p_ff);
            opb = ADD_W'(offset);
         end
         default: begin
         end
      endcase
      sum = opa + opb + ADD_W'(cin);
   end

   assign gate_ext = GW'(gate_ff);
   assign edge_ext = MW'(edge_ff);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      chan_in      = chan_ff;
      ch_ok_in     = ch_ok_ff;
      edge_in      = edge_ff;
      last_in      = last_ff;
      div_in       = div_ff;
      tog_in       = tog_ff;
      gate_in      = gate_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               chan_in  = req_idx;
               ch_ok_in = req_ch_ok;
               cur_in   = req_idx;
               state_in = S_DONE;
               unique case (req_payload.req_type)
                  pacdb_pkg::REQ_CLOCK: begin
                     if (req_payload.clock_level != last_ff) begin
                        last_in  = req_payload.clock_level;
                        state_in = S_INC;
                     end
                  end
                  pacdb_pkg::REQ_RESET: begin
                     edge_in = '0;
                     last_in = 1'b0;
                     gate_in = '0;
                     for (int c = 0; c < NUM_CHANNELS; c++) begin
                        tog_in[c] = TOG_W'(1);
                     end
                  end
                  pacdb_pkg::REQ_SET: begin
                     if (req_ch_ok) begin
                        div_in[req_idx] = req_div;
                        state_in        = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INC: begin
            if (sum > ADD_W'(COUNT_LIMIT)) begin
               edge_in = '0;
            end else begin
               edge_in = sum[CNT_W-1:0];
            end
            cur_in   = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (tog_ff[cur_ff] == TOG_W'(edge_ff)) begin
               gate_in[cur_ff] = ~gate_ff[cur_ff];
               if (sum > ADD_W'(COUNT_LIMIT)) begin
                  tog_in[cur_ff] = TOG_W'(cur_div);
               end else begin
                  tog_in[cur_ff] = sum[TOG_W-1:0];
               end
            end
            if (cur_ff == IDX_W'(NUM_CHANNELS - 1)) begin
               cur_in   = chan_ff;
               state_in = S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            p_in     = sum[TOG_W-1:0];
            state_in = S_SET;
         end
         S_SET: begin
            tog_in[cur_ff] = sum[TOG_W-1:0];
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.gate_outputs    = gate_ext[7:0];
               rsp_in.master_count    = edge_ext[15:0];
               rsp_in.applied_divider = ch_ok_ff ? cur_div : 8'd0;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         chan_ff      <= '0;
         ch_ok_ff     <= 1'b0;
         edge_ff      <= '0;
         last_ff      <= 1'b0;
         gate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            div_ff[c] <= 8'd1;
            tog_ff[c] <= TOG_W'(1);
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         chan_ff      <= chan_in;
         ch_ok_ff     <= ch_ok_in;
         edge_ff      <= edge_in;
         last_ff      <= last_in;
         gate_ff      <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         tog_ff       <= tog_in;
      end
      p_ff   <= p_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> bench/pacdb_checker.sv
`timescale 1ns / 1ps

module pacdb_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  pacdb_pkg::req_payload_type req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  pacdb_pkg::rsp_payload_type rsp_payload,
   output int                         fail_count,
   output int                         outstanding
);

   localparam int              CHANNEL_COUNT = pacdb_pkg::NUM_CHANNELS_DEF;
   localparam longint unsigned EDGE_LIMIT    = pacdb_pkg::COUNT_LIMIT_DEF;

   longint unsigned            master_edges;
   logic                       last_level;
   logic [7:0]                 divider_of [CHANNEL_COUNT];
   longint unsigned            next_toggle [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0]   gate;
   pacdb_pkg::rsp_payload_type expected_rsp [$];
   pacdb_pkg::rsp_payload_type oldest_rsp;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   function automatic void enqueue_expected(input pacdb_pkg::rsp_payload_type rsp_item);
      expected_rsp.insert(expected_rsp.size(), rsp_item);
   endfunction

   function automatic void restart_bank();
      master_edges = 0;
      last_level = 1'b0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         next_toggle[c] = 1;
         gate[c] = 1'b0;
      end
   endfunction

   function automatic pacdb_pkg::rsp_payload_type predict_response(
      input pacdb_pkg::req_payload_type req_item);
      longint unsigned d;
      longint unsigned span;
      longint unsigned base;
      pacdb_pkg::rsp_payload_type result;
      case (req_item.req_type)
         pacdb_pkg::REQ_CLOCK: begin
            if (req_item.clock_level != last_level) begin
               last_level = req_item.clock_level;
               master_edges = (master_edges >= EDGE_LIMIT) ? 0 : master_edges + 1;
               for (int c = 0; c < CHANNEL_COUNT; c++) begin
                  if (next_toggle[c] == master_edges) begin
                     if (next_toggle[c] + divider_of[c] > EDGE_LIMIT) begin
                        next_toggle[c] = divider_of[c];
                     end else begin
                        next_toggle[c] = next_toggle[c] + divider_of[c];
                     end
                     gate[c] = ~gate[c];
                  end
               end
            end
         end
         pacdb_pkg::REQ_RESET: begin
            restart_bank();
         end
         pacdb_pkg::REQ_SET: begin
            divider_of[req_item.channel] =
               (req_item.divider_value == 8'd0) ? 8'd1 : req_item.divider_value;
            d = divider_of[req_item.channel];
            span = 2 * d;
            base = span * (master_edges / span);
            if (!gate[req_item.channel]) begin
               next_toggle[req_item.channel] = base + 2 * d + 1;
            end else if (master_edges < base + d + 1) begin
               next_toggle[req_item.channel] = base + d + 1;
            end else begin
               next_toggle[req_item.channel] = base + 3 * d + 1;
            end
         end
         default: begin
         end
      endcase
      result.gate_outputs = gate[7:0];
      result.master_count = master_edges[15:0];
      result.applied_divider = divider_of[req_item.channel];
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            divider_of[c] = 8'd1;
         end
         restart_bank();
         expected_rsp.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response without request", rsp_payload, 0);
            end else begin
               oldest_rsp = expected_rsp.pop_front();
               if (rsp_payload.gate_outputs !== oldest_rsp.gate_outputs) begin
                  report_mismatch("gate_outputs", rsp_payload.gate_outputs,
                                  oldest_rsp.gate_outputs);
               end
               if (rsp_payload.master_count !== oldest_rsp.master_count) begin
                  report_mismatch("master_count", rsp_payload.master_count,
                                  oldest_rsp.master_count);
               end
               if (rsp_payload.applied_divider !== oldest_rsp.applied_divider) begin
                  report_mismatch("applied_divider", rsp_payload.applied_divider,
                                  oldest_rsp.applied_divider);
               end
            end
         end
         if (req_valid && req_ready) begin
            enqueue_expected(predict_response(req_payload));
         end
         outstanding <= expected_rsp.size();
      end
   end

endmodule

>>> bench/tb_phase_aligned_clock_divider_bank.sv
`timescale 1ns / 1ps

module tb_phase_aligned_clock_divider_bank;

   localparam logic [1:0] REQ_UNUSED      = 2'd3;
   localparam int         RANDOM_REQUESTS = 1950;
   localparam int         HOLD_CYCLES     = 300;
   localparam int         TAIL_CYCLES     = 60;
   localparam int         CYCLE_LIMIT     = 5_000_000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   pacdb_pkg::req_payload_type req_payload;
   logic                       rsp_valid;
   logic                       rsp_ready;
   pacdb_pkg::rsp_payload_type rsp_payload;
   int                         fail_count;
   int                         outstanding;
   int                         cycle_count;
   logic                       level_now;
   logic                       gaps_on;
   logic                       hold_off;

   phase_aligned_clock_divider_bank dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   pacdb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // The receiver idles in random bursts and, on request, holds off for a long stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic pacdb_pkg::req_payload_type make_req(input logic [1:0] kind,
                                                           input logic lvl,
                                                           input logic [2:0] ch,
                                                           input logic [7:0] dv);
      pacdb_pkg::req_payload_type req_item;
      req_item.req_type = kind;
      req_item.clock_level = lvl;
      req_item.channel = ch;
      req_item.divider_value = dv;
      return req_item;
   endfunction

   function automatic logic [7:0] pick_divider();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         return 8'($urandom_range(1, 6));
      end else if (sel == 5) begin
         return 8'd0;
      end else if (sel == 6) begin
         return 8'd255;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_req(input pacdb_pkg::req_payload_type req_item);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= req_item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (req_item.req_type == pacdb_pkg::REQ_CLOCK) begin
         level_now = req_item.clock_level;
      end else if (req_item.req_type == pacdb_pkg::REQ_RESET) begin
         level_now = 1'b0;
      end
   endtask

   task automatic send_edge();
      send_req(make_req(pacdb_pkg::REQ_CLOCK, ~level_now, 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255))));
   endtask

   task automatic send_set();
      send_req(make_req(pacdb_pkg::REQ_SET, 1'($urandom_range(0, 1)),
                        3'($urandom_range(0, 7)), pick_divider()));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int roll;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      level_now = 1'b0;
      gaps_on = 1'b1;
      hold_off = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_req(make_req(pacdb_pkg::REQ_CLOCK, 1'b0, 3'd0, 8'd0));
      send_req(make_req(REQ_UNUSED, 1'b1, 3'd7, 8'hFF));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b0, 3'd0, 8'd0));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b1, 3'd7, 8'd255));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b0, 3'd3, 8'd1));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b1, 3'd1, 8'd2));
      repeat (9) send_edge();
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b0, 3'd0, 8'd2));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b0, 3'd3, 8'd3));
      send_req(make_req(pacdb_pkg::REQ_CLOCK, level_now, 3'd5, 8'hAA));
      send_req(make_req(pacdb_pkg::REQ_RESET, 1'b1, 3'd2, 8'h55));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b1, 3'd5, 8'd170));
      send_req(make_req(pacdb_pkg::REQ_SET, 1'b0, 3'd6, 8'd85));
      send_req(make_req(REQ_UNUSED, 1'b0, 3'd0, 8'd0));
      repeat (3) send_edge();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == 500) begin
            hold_off = 1'b1;
         end
         if (i == 900 || i == 1400) begin
            drain();
         end
         if (i == 1700) begin
            gaps_on = 1'b0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 66) begin
            send_edge();
         end else if (roll < 74) begin
            send_req(make_req(pacdb_pkg::REQ_CLOCK, level_now, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255))));
         end else if (roll < 92) begin
            send_set();
         end else if (roll < 95) begin
            send_req(make_req(pacdb_pkg::REQ_RESET, 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
         end else begin
            send_req(make_req(REQ_UNUSED, 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> phase_aligned_clock_divider_bank.f
src/pacdb_pkg.sv
src/pacdb_rem_div.sv
src/phase_aligned_clock_divider_bank.sv
bench/pacdb_checker.sv
bench/tb_phase_aligned_clock_divider_bank.sv
